[rtl/cmr_pkg.sv]
// shared constants, command codes and controller/datapath types for the reorder block
`default_nettype none

package cmr_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 512;

    localparam int VID_W   = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = 10;
    localparam int DEG_W   = ECNT_W;
    localparam int KEY_W   = DEG_W + VID_W;
    localparam int LADDR_W = VID_W + 1;

    // input item commands
    typedef enum logic [1:0] {
        CMD_LOAD_ROW = 2'd0,
        CMD_LOAD_NB  = 2'd1,
        CMD_RUN      = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_code_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_ROW,
        OP_LOAD_NB,
        OP_DEG_INIT,
        OP_DEG_RD,
        OP_DEG_CALC,
        OP_WALK_INIT,
        OP_Q_RD,
        OP_SPAN_RD,
        OP_SPAN_TAKE,
        OP_NB_RD,
        OP_NB_CHK,
        OP_KDEG,
        OP_INS_RD,
        OP_INS_CMP,
        OP_INS_PUT,
        OP_EMIT,
        OP_LEVEL_NEXT,
        OP_CLEAR,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic n_zero;
        logic deg_last;
        logic nb_done;
        logic add_ok;
        logic m_zero;
        logic cmp_gt;
        logic lvl_last;
        logic nn_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/cmr_datapath.sv]
// datapath: graph memories, degree table, level lists, walk counters and output register
`default_nettype none

module cmr_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmr_pkg::ctl_t        ctl,
    output cmr_pkg::stat_t            stat,
    input  wire logic [9:0]           value,
    output logic [cmr_pkg::VID_W-1:0] vertex,
    output logic                      is_last,
    output logic                      result_valid,
    input  wire logic                 result_stall
);

    localparam int VW = cmr_pkg::VID_W;
    localparam int CW = cmr_pkg::VCNT_W;
    localparam int EW = cmr_pkg::ECNT_W;
    localparam int AW = cmr_pkg::EADDR_W;
    localparam int DW = cmr_pkg::DEG_W;
    localparam int KW = cmr_pkg::KEY_W;
    localparam int LW = cmr_pkg::LADDR_W;

    // memories
    logic [EW-1:0]   row_mem  [cmr_pkg::MAX_VERTICES];
    logic [VW-1:0]   nb_mem   [cmr_pkg::MAX_EDGES];
    logic [2*EW-1:0] span_mem [cmr_pkg::MAX_VERTICES];
    logic [KW-1:0]   list_mem [2*cmr_pkg::MAX_VERTICES];

    logic [EW-1:0]   row_q_reg;
    logic [VW-1:0]   nb_q_reg;
    logic [2*EW-1:0] span_q_reg;
    logic [KW-1:0]   list_q_reg;

    // control registers
    logic [CW-1:0] vcount_reg, vcount_next;
    logic [EW-1:0] ecount_reg, ecount_next;
    logic [cmr_pkg::MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lvl_reg, lvl_next;
    logic [CW-1:0] nn_reg, nn_next;
    logic [CW-1:0] m_reg, m_next;
    logic          bank_reg, bank_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [EW-1:0] prev_reg;
    logic [DW-1:0] min_deg_reg;
    logic [VW-1:0] start_reg;
    logic [VW-1:0] v_reg;
    logic [VW-1:0] w_reg;
    logic [EW-1:0] j_reg;
    logic [EW-1:0] end_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] vertex_reg;
    logic          last_reg;

    // degree, neighbor-check and output arithmetic
    logic [EW-1:0] hi0, hi;
    logic [DW-1:0] deg;
    logic [DW-1:0] kdeg;
    logic          add;
    logic          out_take;
    logic          emit_last;

    always_comb
    begin
        hi0  = (row_q_reg < ecount_reg) ? row_q_reg : ecount_reg;
        hi   = (hi0 < prev_reg) ? prev_reg : hi0;
        deg  = hi - prev_reg;
        kdeg = span_q_reg[EW-1:0] - span_q_reg[2*EW-1:EW];
        add  = ({1'b0, nb_q_reg} < vcount_reg) && !visited_reg[nb_q_reg]
               && (nn_reg < CW'(cmr_pkg::MAX_VERTICES));
        out_take  = out_valid_reg && !result_stall;
        emit_last = (idx_reg + CW'(1) == lvl_reg) && (nn_reg == '0);
    end

    // status to the controller
    always_comb
    begin
        stat.n_zero   = (vcount_reg == '0);
        stat.deg_last = (idx_reg + CW'(1) == vcount_reg);
        stat.nb_done  = (j_reg == end_reg);
        stat.add_ok   = add;
        stat.m_zero   = (m_reg == '0);
        stat.cmp_gt   = (list_q_reg > key_reg);
        stat.lvl_last = (idx_reg + CW'(1) == lvl_reg);
        stat.nn_zero  = (nn_reg == '0);
        stat.out_free = !out_valid_reg || !result_stall;
    end

    // next-state of counters and flags
    always_comb
    begin
        vcount_next    = vcount_reg;
        ecount_next    = ecount_reg;
        visited_next   = visited_reg;
        idx_next       = idx_reg;
        lvl_next       = lvl_reg;
        nn_next        = nn_reg;
        m_next         = m_reg;
        bank_next      = bank_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        unique case (ctl.op)
            cmr_pkg::OP_LOAD_ROW:
            begin
                if (vcount_reg < CW'(cmr_pkg::MAX_VERTICES))
                    vcount_next = vcount_reg + CW'(1);
            end
            cmr_pkg::OP_LOAD_NB:
            begin
                if (ecount_reg < EW'(cmr_pkg::MAX_EDGES))
                    ecount_next = ecount_reg + EW'(1);
            end
            cmr_pkg::OP_DEG_INIT:
                idx_next = '0;
            cmr_pkg::OP_DEG_CALC:
                idx_next = idx_reg + CW'(1);
            cmr_pkg::OP_WALK_INIT:
            begin
                visited_next = '0;
                visited_next[start_reg] = 1'b1;
                idx_next  = '0;
                lvl_next  = CW'(1);
                nn_next   = '0;
                bank_next = 1'b0;
            end
            cmr_pkg::OP_NB_CHK:
            begin
                if (add)
                    visited_next[nb_q_reg] = 1'b1;
            end
            cmr_pkg::OP_KDEG:
                m_next = nn_reg;
            cmr_pkg::OP_INS_CMP:
            begin
                if (list_q_reg > key_reg)
                    m_next = m_reg - CW'(1);
            end
            cmr_pkg::OP_INS_PUT:
                nn_next = nn_reg + CW'(1);
            cmr_pkg::OP_EMIT:
            begin
                idx_next       = idx_reg + CW'(1);
                out_valid_next = 1'b1;
            end
            cmr_pkg::OP_LEVEL_NEXT:
            begin
                bank_next = ~bank_reg;
                lvl_next  = nn_reg;
                nn_next   = '0;
                idx_next  = '0;
            end
            cmr_pkg::OP_CLEAR:
            begin
                vcount_next = '0;
                ecount_next = '0;
            end
            cmr_pkg::OP_EMPTY:
            begin
                vcount_next    = '0;
                ecount_next    = '0;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            ecount_reg    <= '0;
            visited_reg   <= '0;
            idx_reg       <= '0;
            lvl_reg       <= '0;
            nn_reg        <= '0;
            m_reg         <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            ecount_reg    <= ecount_next;
            visited_reg   <= visited_next;
            idx_reg       <= idx_next;
            lvl_reg       <= lvl_next;
            nn_reg        <= nn_next;
            m_reg         <= m_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            cmr_pkg::OP_LOAD_ROW:
            begin
                if (vcount_reg < CW'(cmr_pkg::MAX_VERTICES))
                    row_mem[vcount_reg[VW-1:0]] <= value;
            end
            cmr_pkg::OP_LOAD_NB:
            begin
                if (ecount_reg < EW'(cmr_pkg::MAX_EDGES))
                    nb_mem[ecount_reg[AW-1:0]] <= value[VW-1:0];
            end
            cmr_pkg::OP_DEG_INIT:
            begin
                prev_reg    <= '0;
                min_deg_reg <= '1;
                start_reg   <= '0;
            end
            cmr_pkg::OP_DEG_RD:
                row_q_reg <= row_mem[idx_reg[VW-1:0]];
            cmr_pkg::OP_DEG_CALC:
            begin
                span_mem[idx_reg[VW-1:0]] <= {prev_reg, hi};
                if (deg < min_deg_reg)
                begin
                    min_deg_reg <= deg;
                    start_reg   <= idx_reg[VW-1:0];
                end
                prev_reg <= hi0;
            end
            cmr_pkg::OP_WALK_INIT:
                list_mem[{1'b0, VW'(0)}] <= {DW'(0), start_reg};
            cmr_pkg::OP_Q_RD:
                list_q_reg <= list_mem[{bank_reg, idx_reg[VW-1:0]}];
            cmr_pkg::OP_SPAN_RD:
            begin
                v_reg      <= list_q_reg[VW-1:0];
                span_q_reg <= span_mem[list_q_reg[VW-1:0]];
            end
            cmr_pkg::OP_SPAN_TAKE:
            begin
                j_reg   <= span_q_reg[2*EW-1:EW];
                end_reg <= span_q_reg[EW-1:0];
            end
            cmr_pkg::OP_NB_RD:
            begin
                nb_q_reg <= nb_mem[j_reg[AW-1:0]];
                j_reg    <= j_reg + EW'(1);
            end
            cmr_pkg::OP_NB_CHK:
            begin
                w_reg      <= nb_q_reg;
                span_q_reg <= span_mem[nb_q_reg];
            end
            cmr_pkg::OP_KDEG:
                key_reg <= {kdeg, w_reg};
            cmr_pkg::OP_INS_RD:
                list_q_reg <= list_mem[{~bank_reg, VW'(m_reg - CW'(1))}];
            cmr_pkg::OP_INS_CMP:
            begin
                if (list_q_reg > key_reg)
                    list_mem[{~bank_reg, m_reg[VW-1:0]}] <= list_q_reg;
            end
            cmr_pkg::OP_INS_PUT:
                list_mem[{~bank_reg, m_reg[VW-1:0]}] <= key_reg;
            cmr_pkg::OP_EMIT:
            begin
                vertex_reg <= v_reg;
                last_reg   <= emit_last;
            end
            cmr_pkg::OP_EMPTY:
            begin
                vertex_reg <= '0;
                last_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign vertex       = vertex_reg;
    assign is_last      = last_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/cmr_ctrl.sv]
// controller: sequences loads, degree scan, breadth-first walk, level insertion and emission
`default_nettype none

module cmr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic [1:0]     cmd,
    output logic                item_stall,
    input  wire cmr_pkg::stat_t stat,
    output cmr_pkg::ctl_t       ctl
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEG_RD,
        S_DEG_CALC,
        S_WALK_INIT,
        S_Q_RD,
        S_SPAN_RD,
        S_SPAN_TAKE,
        S_NB_NEXT,
        S_NB_RD,
        S_NB_CHK,
        S_KDEG,
        S_INS_CHK,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_EMIT,
        S_LEVEL_NEXT,
        S_CLEAR,
        S_EMPTY
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        ctl.op     = cmr_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        cmr_pkg::CMD_LOAD_ROW: ctl.op = cmr_pkg::OP_LOAD_ROW;
                        cmr_pkg::CMD_LOAD_NB:  ctl.op = cmr_pkg::OP_LOAD_NB;
                        cmr_pkg::CMD_RUN:
                        begin
                            if (stat.n_zero)
                                state_next = S_EMPTY;
                            else
                            begin
                                ctl.op     = cmr_pkg::OP_DEG_INIT;
                                state_next = S_DEG_RD;
                            end
                        end
                        default: ctl.op = cmr_pkg::OP_NONE;
                    endcase
                end
            end
            S_DEG_RD:
            begin
                ctl.op     = cmr_pkg::OP_DEG_RD;
                state_next = S_DEG_CALC;
            end
            S_DEG_CALC:
            begin
                ctl.op     = cmr_pkg::OP_DEG_CALC;
                state_next = stat.deg_last ? S_WALK_INIT : S_DEG_RD;
            end
            S_WALK_INIT:
            begin
                ctl.op     = cmr_pkg::OP_WALK_INIT;
                state_next = S_Q_RD;
            end
            S_Q_RD:
            begin
                ctl.op     = cmr_pkg::OP_Q_RD;
                state_next = S_SPAN_RD;
            end
            S_SPAN_RD:
            begin
                ctl.op     = cmr_pkg::OP_SPAN_RD;
                state_next = S_SPAN_TAKE;
            end
            S_SPAN_TAKE:
            begin
                ctl.op     = cmr_pkg::OP_SPAN_TAKE;
                state_next = S_NB_NEXT;
            end
            S_NB_NEXT:
                state_next = stat.nb_done ? S_EMIT : S_NB_RD;
            S_NB_RD:
            begin
                ctl.op     = cmr_pkg::OP_NB_RD;
                state_next = S_NB_CHK;
            end
            S_NB_CHK:
            begin
                ctl.op     = cmr_pkg::OP_NB_CHK;
                state_next = stat.add_ok ? S_KDEG : S_NB_NEXT;
            end
            S_KDEG:
            begin
                ctl.op     = cmr_pkg::OP_KDEG;
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
                state_next = stat.m_zero ? S_INS_PUT : S_INS_RD;
            S_INS_RD:
            begin
                ctl.op     = cmr_pkg::OP_INS_RD;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                ctl.op     = cmr_pkg::OP_INS_CMP;
                state_next = stat.cmp_gt ? S_INS_CHK : S_INS_PUT;
            end
            S_INS_PUT:
            begin
                ctl.op     = cmr_pkg::OP_INS_PUT;
                state_next = S_NB_NEXT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.op = cmr_pkg::OP_EMIT;
                    if (!stat.lvl_last)
                        state_next = S_Q_RD;
                    else if (stat.nn_zero)
                        state_next = S_CLEAR;
                    else
                        state_next = S_LEVEL_NEXT;
                end
            end
            S_LEVEL_NEXT:
            begin
                ctl.op     = cmr_pkg::OP_LEVEL_NEXT;
                state_next = S_Q_RD;
            end
            S_CLEAR:
            begin
                ctl.op     = cmr_pkg::OP_CLEAR;
                state_next = S_IDLE;
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = cmr_pkg::OP_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[rtl/cuthill_mckee_reorder_top.sv]
// top level of the Cuthill-McKee reorder block: controller plus datapath
//
// Input channel (item_valid/item_stall, fields cmd and value): cmd 0 loads the
// next row-end offset, cmd 1 the next neighbor id, cmd 2 runs the ordering,
// cmd 3 is ignored. Loads are taken one per cycle; loads past 64 rows or 512
// neighbors are dropped. A run holds item_stall high until it finishes.
// Output channel (result_valid/result_stall, fields vertex and is_last): one
// item per visited vertex in visit order, is_last on the final one. An empty
// graph gives vertex 0 with is_last set. Unreachable vertices are skipped.
// Run: a degree scan reads each loaded row offset and picks the first vertex of
// least degree as start; the walk then reads each visited vertex's neighbor
// entries, and each vertex added to the next level is inserted in order of
// degree, then vertex id, by shifting larger entries up until a compare ends
// the shift. Memory reads are registered and the level list is single-ported.
// A stalled result sits in the output register; the walk goes on until the
// next result is ready, then waits. Reset clears counts, visit marks and the
// controller; memory contents are left as they are.
`default_nettype none

module cuthill_mckee_reorder_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [9:0]           value,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [cmr_pkg::VID_W-1:0] vertex,
    output logic                      is_last
);

    cmr_pkg::ctl_t  ctl;
    cmr_pkg::stat_t stat;

    cmr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .cmd        (cmd),
        .item_stall (item_stall),
        .stat       (stat),
        .ctl        (ctl)
    );

    cmr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .value        (value),
        .vertex       (vertex),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

[rtl/cmr_checker.sv]
// port-level checker for the reorder block and its bind to the top level
`default_nettype none

module cmr_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_stall,
    input wire logic [1:0]           cmd,
    input wire logic [9:0]           value,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire logic [cmr_pkg::VID_W-1:0] vertex,
    input wire logic                 is_last
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(vertex) && $stable(is_last))
        else $error("stalled result changed");

    // a stalled input item holds
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(cmd) && $stable(value))
        else $error("stalled input item changed");

    // a run item blocks further input
    a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd == cmr_pkg::CMD_RUN) |=> item_stall)
        else $error("input not stalled after run item");

    // load items keep the input open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall
        && ((cmd == cmr_pkg::CMD_LOAD_ROW) || (cmd == cmr_pkg::CMD_LOAD_NB))
        |=> !item_stall)
        else $error("input stalled after load item");

endmodule

bind cuthill_mckee_reorder_top cmr_checker u_cmr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .vertex       (vertex),
    .is_last      (is_last)
);

`default_nettype wire
